FILE: rtl/abkf_pkg.sv
// Shared types, register indexes and the step program of the angle/bias Kalman filter.
package abkf_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_Q_ANGLE   = 2'd0;
  localparam logic [1:0] CFG_Q_BIAS    = 2'd1;
  localparam logic [1:0] CFG_R_MEAS    = 2'd2;
  localparam logic [1:0] CFG_TIME_STEP = 2'd3;

  // Operations of the shared arithmetic unit.
  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } op_t;

  // Operand and destination selects of the working register set.
  typedef enum logic [4:0] {
    R_ANG,
    R_BIAS,
    R_C00,
    R_C01,
    R_C10,
    R_C11,
    R_AM,
    R_RM,
    R_ERR,
    R_E,
    R_K0,
    R_K1,
    R_T0,
    R_T1,
    R_T2,
    R_DT,
    R_QA,
    R_QB,
    R_RR
  } reg_sel_t;

  // One step of the program: dst = src_a op src_b.
  typedef struct packed {
    op_t      op;
    reg_sel_t dst;
    reg_sel_t src_a;
    reg_sel_t src_b;
  } micro_t;

  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] PROG_LAST = 5'd28;

  // Predict, gain and correct sequence for one sample. Products that use an old
  // covariance term are taken before that term is overwritten.
  function automatic micro_t micro_at(input logic [STEP_W-1:0] idx);
    micro_t m;
    unique case (idx)
      5'd0:    m = '{OP_SUB, R_T0,   R_RM,  R_BIAS};
      5'd1:    m = '{OP_MUL, R_T0,   R_T0,  R_DT};
      5'd2:    m = '{OP_ADD, R_ANG,  R_ANG, R_T0};
      5'd3:    m = '{OP_SUB, R_T0,   R_QA,  R_C01};
      5'd4:    m = '{OP_SUB, R_T0,   R_T0,  R_C10};
      5'd5:    m = '{OP_MUL, R_T0,   R_T0,  R_DT};
      5'd6:    m = '{OP_ADD, R_C00,  R_C00, R_T0};
      5'd7:    m = '{OP_MUL, R_T0,   R_C11, R_DT};
      5'd8:    m = '{OP_SUB, R_C01,  R_C01, R_T0};
      5'd9:    m = '{OP_SUB, R_C10,  R_C10, R_T0};
      5'd10:   m = '{OP_MUL, R_T0,   R_QB,  R_DT};
      5'd11:   m = '{OP_ADD, R_C11,  R_C11, R_T0};
      5'd12:   m = '{OP_SUB, R_ERR,  R_AM,  R_ANG};
      5'd13:   m = '{OP_ADD, R_E,    R_RR,  R_C00};
      5'd14:   m = '{OP_DIV, R_K0,   R_C00, R_E};
      5'd15:   m = '{OP_DIV, R_K1,   R_C10, R_E};
      5'd16:   m = '{OP_MUL, R_T0,   R_K0,  R_C00};
      5'd17:   m = '{OP_MUL, R_T1,   R_K1,  R_C00};
      5'd18:   m = '{OP_SUB, R_C00,  R_C00, R_T0};
      5'd19:   m = '{OP_MUL, R_T0,   R_K0,  R_C01};
      5'd20:   m = '{OP_MUL, R_T2,   R_K1,  R_C01};
      5'd21:   m = '{OP_SUB, R_C01,  R_C01, R_T0};
      5'd22:   m = '{OP_SUB, R_C10,  R_C10, R_T1};
      5'd23:   m = '{OP_SUB, R_C11,  R_C11, R_T2};
      5'd24:   m = '{OP_MUL, R_T0,   R_K0,  R_ERR};
      5'd25:   m = '{OP_ADD, R_ANG,  R_ANG, R_T0};
      5'd26:   m = '{OP_MUL, R_T0,   R_K1,  R_ERR};
      5'd27:   m = '{OP_ADD, R_BIAS, R_BIAS, R_T0};
      5'd28:   m = '{OP_SUB, R_T1,   R_RM,  R_BIAS};
      default: m = '{OP_ADD, R_T2,   R_T2,  R_T2};
    endcase
    return m;
  endfunction

endpackage

FILE: rtl/angle_bias_kalman_filter.sv
// Two-state Kalman filter for tilt angle and gyro bias, built around one shared arithmetic unit.
// Each sample transfer on the slave side starts a fixed 29-step program run by a small sequencer
// over one saturating adder, one byte-serial multiplier and one restoring divider. The default format
// is Q15.32. The two gain divisions, one quotient bit per cycle, take most of the time of a sample,
// and the ten multiplies, one byte of the multiplier per cycle, most of the rest. A division whose
// divisor is not positive skips the divider and writes a zero gain. s_tready is high only while no
// sample is being worked on, and it rises again in the cycle the result is loaded into the output
// register. The result waits in that output register, so the next sample is taken while the master
// side is stalled. All values are signed fixed point with FRAC_BITS fraction bits; every operation
// truncates toward zero and saturates.
module angle_bias_kalman_filter #(
  parameter int DATA_WIDTH = 48,
  parameter int FRAC_BITS  = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // Configuration write port.
  input  logic                                  cfg_we,
  input  logic [1:0]                            cfg_index,
  input  logic [DATA_WIDTH-2:0]                 cfg_data,
  // Sample input.
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]     s_tdata,  // angle_meas, rate_meas
  // Result output.
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [((2*DATA_WIDTH+7)/8)*8-1:0]     m_tdata   // angle_out, rate_out
);

  import abkf_pkg::*;

  localparam int W      = DATA_WIDTH;
  localparam int TD_W   = ((2*W+7)/8)*8;
  localparam int ND     = (W+7)/8;
  localparam int MY_W   = 8*ND;
  localparam int ACC_W  = (2*W > W+FRAC_BITS+1) ? 2*W : W+FRAC_BITS+1;
  localparam int DIV_N  = W + FRAC_BITS;
  localparam int CNT_W  = $clog2(DIV_N+1);

  localparam logic signed [W-1:0] MAX_V = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MIN_V = {1'b1, {(W-1){1'b0}}};

  // Reset values: 2^FRAC_BITS times the constant, rounded.
  localparam logic [63:0] ONE_FX  = 64'd1 << FRAC_BITS;
  localparam logic [63:0] QA_RST  = (ONE_FX + 64'd500) / 64'd1000;
  localparam logic [63:0] QB_RST  = (64'd3 * ONE_FX + 64'd500) / 64'd1000;
  localparam logic [63:0] RR_RST  = 64'd10 * ONE_FX;
  localparam logic [63:0] DT_RST  = (64'd5 * ONE_FX + 64'd500) / 64'd1000;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_MUL  = 5'b00100,
    S_DIV  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state;
  logic [STEP_W-1:0] step;
  logic [CNT_W-1:0]  cnt;
  micro_t            cur;

  // Configuration registers.
  logic [W-2:0] q_angle, q_bias_noise, r_meas, time_step;

  // Filter state and working registers.
  logic signed [W-1:0] ang, bias, c00, c01, c10, c11;
  logic signed [W-1:0] am, rm, err, e_sum, k0, k1, t0, t1, t2;

  // Multiplier and divider registers.
  logic [W-1:0]     mx;
  logic [MY_W-1:0]  my;
  logic [ACC_W-1:0] acc;
  logic [DIV_N-1:0] dvd;
  logic [W-1:0]     dv;
  logic [W-1:0]     rem;
  logic             neg;

  // Output register.
  logic             out_valid;
  logic signed [W-1:0] out_angle, out_rate;

  logic signed [W-1:0] opa, opb;
  logic signed [W-1:0] alu_res, mul_res, div_res, wr_val;
  logic                wr_en;
  logic                in_xfer, out_load;

  assign cur      = micro_at(step);
  assign s_tready = (state == S_IDLE);
  assign in_xfer  = s_tvalid && s_tready;
  assign out_load = (state == S_OUT) && (!out_valid || m_tready);
  assign m_tvalid = out_valid;
  assign m_tdata  = TD_W'({out_rate, out_angle});

  function automatic logic signed [W-1:0] read_sel(input reg_sel_t s,
      input logic signed [W-1:0] v_ang, v_bias, v_c00, v_c01, v_c10, v_c11,
      input logic signed [W-1:0] v_am, v_rm, v_err, v_e, v_k0, v_k1, v_t0, v_t1, v_t2,
      input logic [W-2:0] v_dt, v_qa, v_qb, v_rr);
    logic signed [W-1:0] v;
    unique case (s)
      R_ANG:   v = v_ang;
      R_BIAS:  v = v_bias;
      R_C00:   v = v_c00;
      R_C01:   v = v_c01;
      R_C10:   v = v_c10;
      R_C11:   v = v_c11;
      R_AM:    v = v_am;
      R_RM:    v = v_rm;
      R_ERR:   v = v_err;
      R_E:     v = v_e;
      R_K0:    v = v_k0;
      R_K1:    v = v_k1;
      R_T0:    v = v_t0;
      R_T1:    v = v_t1;
      R_T2:    v = v_t2;
      R_DT:    v = {1'b0, v_dt};
      R_QA:    v = {1'b0, v_qa};
      R_QB:    v = {1'b0, v_qb};
      R_RR:    v = {1'b0, v_rr};
      default: v = '0;
    endcase
    return v;
  endfunction

  // Operand selection for the current step.
  always_comb begin
    opa = read_sel(cur.src_a, ang, bias, c00, c01, c10, c11, am, rm, err, e_sum,
                   k0, k1, t0, t1, t2, time_step, q_angle, q_bias_noise, r_meas);
    opb = read_sel(cur.src_b, ang, bias, c00, c01, c10, c11, am, rm, err, e_sum,
                   k0, k1, t0, t1, t2, time_step, q_angle, q_bias_noise, r_meas);
  end

  // Saturating add and subtract.
  logic signed [W:0] ae, be, sum;
  always_comb begin
    ae  = {opa[W-1], opa};
    be  = {opb[W-1], opb};
    sum = (cur.op == OP_SUB) ? (ae - be) : (ae + be);
    if (sum[W] != sum[W-1]) begin
      alu_res = sum[W] ? MIN_V : MAX_V;
    end else begin
      alu_res = sum[W-1:0];
    end
  end

  // Magnitudes of the operands for the multiplier and divider.
  logic [W-1:0] mag_a, mag_b;
  assign mag_a = opa[W-1] ? W'(-opa) : W'(opa);
  assign mag_b = opb[W-1] ? W'(-opb) : W'(opb);

  // Byte step of the multiplier: most significant byte of the second operand first.
  logic [W+7:0]     pp;
  logic [ACC_W-1:0] acc_next;
  assign pp       = mx * my[MY_W-1 -: 8];
  assign acc_next = {acc[ACC_W-9:0], 8'h00} + ACC_W'(pp);

  // Scaled and saturated product.
  logic             mul_sat;
  logic [W-2:0]     mul_mag;
  always_comb begin
    mul_sat = |acc[ACC_W-1:W-1+FRAC_BITS];
    mul_mag = acc[W-2+FRAC_BITS:FRAC_BITS];
    if (mul_sat) begin
      mul_res = neg ? MIN_V : MAX_V;
    end else begin
      mul_res = neg ? -$signed({1'b0, mul_mag}) : $signed({1'b0, mul_mag});
    end
  end

  // Restoring divider step: one quotient bit shifts into the dividend register.
  logic [W:0]   rt, rdiff;
  logic         q_bit;
  logic [W-1:0] rem_next;
  always_comb begin
    rt       = {rem, dvd[DIV_N-1]};
    rdiff    = rt - {1'b0, dv};
    q_bit    = (rt >= {1'b0, dv});
    rem_next = q_bit ? rdiff[W-1:0] : rt[W-1:0];
  end

  // Saturated quotient.
  logic         div_sat;
  logic [W-2:0] div_mag;
  always_comb begin
    div_sat = |dvd[DIV_N-1:W-1];
    div_mag = dvd[W-2:0];
    if (div_sat) begin
      div_res = neg ? MIN_V : MAX_V;
    end else begin
      div_res = neg ? -$signed({1'b0, div_mag}) : $signed({1'b0, div_mag});
    end
  end

  // A non-positive divisor gives a zero gain.
  logic div_zero;
  assign div_zero = opb[W-1] || (opb == '0);

  // Single write port into the working register set.
  always_comb begin
    wr_en  = 1'b0;
    wr_val = alu_res;
    unique case (state)
      S_EXEC: begin
        if (cur.op == OP_ADD || cur.op == OP_SUB) begin
          wr_en = 1'b1;
        end else if (cur.op == OP_DIV && div_zero) begin
          wr_en  = 1'b1;
          wr_val = '0;
        end
      end
      S_MUL: begin
        if (cnt == CNT_W'(ND)) begin
          wr_en  = 1'b1;
          wr_val = mul_res;
        end
      end
      S_DIV: begin
        if (cnt == CNT_W'(DIV_N)) begin
          wr_en  = 1'b1;
          wr_val = div_res;
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Sequencer and output handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            step  <= '0;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          cnt <= '0;
          if (cur.op == OP_MUL) begin
            state <= S_MUL;
          end else if (cur.op == OP_DIV && !div_zero) begin
            state <= S_DIV;
          end
        end
        S_MUL, S_DIV: begin
          if (!wr_en) begin
            cnt <= cnt + 1'b1;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      // A finished step moves the program on.
      if (wr_en) begin
        if (step == PROG_LAST) begin
          state <= S_OUT;
        end else begin
          step  <= step + 1'b1;
          state <= S_EXEC;
        end
      end
    end
  end

  // Multiplier and divider datapath.
  always_ff @(posedge clk) begin
    if (state == S_EXEC) begin
      neg <= opa[W-1] ^ ((cur.op == OP_MUL) ? opb[W-1] : 1'b0);
      mx  <= mag_a;
      my  <= MY_W'(mag_b);
      acc <= '0;
      dvd <= {mag_a, {FRAC_BITS{1'b0}}};
      dv  <= opb;
      rem <= '0;
    end else if (state == S_MUL && !wr_en) begin
      acc <= acc_next;
      my  <= {my[MY_W-9:0], 8'h00};
    end else if (state == S_DIV && !wr_en) begin
      rem <= rem_next;
      dvd <= {dvd[DIV_N-2:0], q_bit};
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      q_angle      <= QA_RST[W-2:0];
      q_bias_noise <= QB_RST[W-2:0];
      r_meas       <= RR_RST[W-2:0];
      time_step    <= DT_RST[W-2:0];
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_Q_ANGLE:   q_angle      <= cfg_data;
        CFG_Q_BIAS:    q_bias_noise <= cfg_data;
        CFG_R_MEAS:    r_meas       <= cfg_data;
        CFG_TIME_STEP: time_step    <= cfg_data;
        default:       q_angle      <= q_angle;
      endcase
    end
  end

  // Filter state: angle, bias and covariance.
  always_ff @(posedge clk) begin
    if (rst) begin
      ang  <= '0;
      bias <= '0;
      c00  <= ONE_FX[W-1:0];
      c01  <= '0;
      c10  <= '0;
      c11  <= ONE_FX[W-1:0];
    end else if (wr_en) begin
      unique case (cur.dst)
        R_ANG:   ang  <= wr_val;
        R_BIAS:  bias <= wr_val;
        R_C00:   c00  <= wr_val;
        R_C01:   c01  <= wr_val;
        R_C10:   c10  <= wr_val;
        R_C11:   c11  <= wr_val;
        default: ang  <= ang;
      endcase
    end
  end

  // Sample registers and temporaries.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      am <= s_tdata[W-1:0];
      rm <= s_tdata[2*W-1:W];
    end
    if (wr_en) begin
      unique case (cur.dst)
        R_ERR:   err   <= wr_val;
        R_E:     e_sum <= wr_val;
        R_K0:    k0    <= wr_val;
        R_K1:    k1    <= wr_val;
        R_T0:    t0    <= wr_val;
        R_T1:    t1    <= wr_val;
        R_T2:    t2    <= wr_val;
        default: t2    <= t2;
      endcase
    end
    if (out_load) begin
      out_angle <= ang;
      out_rate  <= t1;
    end
  end

endmodule
